// File: design/tspi_pkg.sv
`timescale 1ns / 1ps
package tspi_pkg;

    localparam int HistDepth = 20;
    localparam int SlotCount = 16;
    localparam int FifoDepth = 2;
    localparam int MemDepth  = SlotCount * HistDepth;

    localparam logic [1:0] OP_STORE  = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_SPARE  = 2'd3;

    localparam logic [1:0] KIND_NOP   = 2'd0;
    localparam logic [1:0] KIND_STORE = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [8:0]  addr;
        logic [4:0]  head;
        logic [4:0]  count;
        logic [23:0] x;
        logic [23:0] y;
        logic [31:0] tstamp;
    } t_cmd;

    typedef struct packed {
        logic [23:0] x;
        logic [23:0] y;
        logic [31:0] tstamp;
    } t_sample;

    function automatic logic [8:0] phys(logic [3:0] slot, logic [4:0] head, logic [4:0] k);
        logic [5:0] s;
        logic [8:0] base;
        s = {1'b0, head} + {1'b0, k};
        if (s >= 6'(HistDepth)) begin
            s = s - 6'(HistDepth);
        end
        base = 9'(slot) * 9'(HistDepth);
        return base + 9'(s);
    endfunction

endpackage

// File: design/tspi_front.sv
`timescale 1ns / 1ps
module tspi_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_op,
    input  logic [3:0]        i_slot,
    input  logic [23:0]       i_x,
    input  logic [23:0]       i_y,
    input  logic [31:0]       i_now,
    input  logic              i_full,
    output logic              o_push,
    output tspi_pkg::t_cmd    o_cmd
);

    logic [4:0]  r_head [tspi_pkg::SlotCount];
    logic [4:0]  r_count [tspi_pkg::SlotCount];
    logic [15:0] r_delay;
    logic [4:0]  w_head;
    logic [4:0]  w_count;
    logic        w_full_ring;

    assign w_head      = r_head[i_slot];
    assign w_count     = r_count[i_slot];
    assign w_full_ring = (w_count >= 5'(tspi_pkg::HistDepth));
    assign o_ready     = !i_full;
    assign o_push      = i_valid && !i_full;

    always_comb begin
        o_cmd        = '0;
        o_cmd.kind   = tspi_pkg::KIND_NOP;
        o_cmd.slot   = i_slot;
        o_cmd.head   = w_head;
        o_cmd.count  = w_count;
        o_cmd.x      = i_x;
        o_cmd.y      = i_y;
        o_cmd.tstamp = i_now;
        o_cmd.addr   = tspi_pkg::phys(i_slot, w_head, w_full_ring ? 5'd0 : w_count);
        case (i_op)
            tspi_pkg::OP_STORE: begin
                o_cmd.kind = tspi_pkg::KIND_STORE;
            end
            tspi_pkg::OP_QUERY: begin
                o_cmd.tstamp = i_now - {16'd0, r_delay};
                if (i_now >= {16'd0, r_delay} && w_count >= 5'd2) begin
                    o_cmd.kind = tspi_pkg::KIND_QUERY;
                end
            end
            default: begin
                o_cmd.kind = tspi_pkg::KIND_NOP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= 16'd100;
            for (int i = 0; i < tspi_pkg::SlotCount; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_delay <= i_cfg_wdata;
            end
            if (o_push) begin
                case (i_op)
                    tspi_pkg::OP_STORE: begin
                        if (!w_full_ring) begin
                            r_count[i_slot] <= w_count + 5'd1;
                        end else if (w_head == 5'(tspi_pkg::HistDepth - 1)) begin
                            r_head[i_slot] <= '0;
                        end else begin
                            r_head[i_slot] <= w_head + 5'd1;
                        end
                    end
                    tspi_pkg::OP_REMOVE: begin
                        r_head[i_slot]  <= '0;
                        r_count[i_slot] <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// File: design/tspi_fifo.sv
`timescale 1ns / 1ps
module tspi_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tspi_pkg::t_cmd    i_data,
    input  logic              i_pop,
    output tspi_pkg::t_cmd    o_data,
    output logic              o_full,
    output logic              o_empty
);

    tspi_pkg::t_cmd r_mem [tspi_pkg::FifoDepth];
    logic [$clog2(tspi_pkg::FifoDepth)-1:0] r_wp;
    logic [$clog2(tspi_pkg::FifoDepth)-1:0] r_rp;
    logic [$clog2(tspi_pkg::FifoDepth):0]   r_cnt;

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == ($clog2(tspi_pkg::FifoDepth)+1)'(tspi_pkg::FifoDepth));
    assign o_empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: design/tspi_back.sv
`timescale 1ns / 1ps
module tspi_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  tspi_pkg::t_cmd    i_cmd,
    output logic              o_pop,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    output logic              o_res_valid,
    output logic [23:0]       o_x,
    output logic [23:0]       o_y
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_MULX   = 3'd3;
    localparam logic [2:0] ST_ADDX   = 3'd4;
    localparam logic [2:0] ST_ADDY   = 3'd5;

    tspi_pkg::t_sample r_mem [tspi_pkg::MemDepth];
    tspi_pkg::t_sample r_rd;
    tspi_pkg::t_sample r_prev;
    tspi_pkg::t_sample r_a;

    logic [2:0]  r_state;
    logic [3:0]  r_slot;
    logic [4:0]  r_head;
    logic [4:0]  r_count;
    logic [31:0] r_render;
    logic [4:0]  r_k;
    logic [4:0]  r_kd;
    logic        r_iss;
    logic        r_pend;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [15:0] r_q;
    logic [3:0]  r_dcnt;
    logic [23:0] r_prod;
    logic [23:0] r_xo;
    logic        r_out_v;
    logic        r_out_res;
    logic [23:0] r_out_x;
    logic [23:0] r_out_y;

    logic               w_we;
    logic [8:0]         w_rd_addr;
    logic [32:0]        w_rem2;
    logic signed [24:0] w_d;
    logic signed [41:0] w_prod;

    assign o_pop       = (r_state == ST_IDLE) && !i_empty && !r_out_v;
    assign w_we        = o_pop && (i_cmd.kind == tspi_pkg::KIND_STORE);
    assign w_rd_addr   = tspi_pkg::phys(r_slot, r_head, r_k);
    assign w_rem2      = {r_rem[31:0], 1'b0};
    assign w_d         = (r_state == ST_MULX)
                       ? ($signed({r_prev.x[23], r_prev.x}) - $signed({r_a.x[23], r_a.x}))
                       : ($signed({r_prev.y[23], r_prev.y}) - $signed({r_a.y[23], r_a.y}));
    assign w_prod      = w_d * $signed({1'b0, r_q});
    assign o_m_valid   = r_out_v;
    assign o_res_valid = r_out_res;
    assign o_x         = r_out_x;
    assign o_y         = r_out_y;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[i_cmd.addr] <= {i_cmd.x, i_cmd.y, i_cmd.tstamp};
        end
        r_rd <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_v <= 1'b0;
            r_iss   <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            if (r_out_v && i_m_ready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_slot   <= i_cmd.slot;
                        r_head   <= i_cmd.head;
                        r_count  <= i_cmd.count;
                        r_render <= i_cmd.tstamp;
                        r_k      <= i_cmd.count - 5'd1;
                        if (i_cmd.kind == tspi_pkg::KIND_QUERY) begin
                            r_iss   <= 1'b1;
                            r_pend  <= 1'b0;
                            r_state <= ST_SEARCH;
                        end else begin
                            r_out_v   <= 1'b1;
                            r_out_res <= 1'b0;
                            r_out_x   <= '0;
                            r_out_y   <= '0;
                        end
                    end
                end
                ST_SEARCH: begin
                    if (r_iss) begin
                        r_kd  <= r_k;
                        r_k   <= r_k - 5'd1;
                        r_iss <= (r_k != 5'd0);
                    end
                    r_pend <= r_iss;
                    if (r_pend) begin
                        if (r_rd.tstamp <= r_render) begin
                            r_iss  <= 1'b0;
                            r_pend <= 1'b0;
                            if (r_kd == r_count - 5'd1) begin
                                r_out_v   <= 1'b1;
                                r_out_res <= 1'b0;
                                r_out_x   <= '0;
                                r_out_y   <= '0;
                                r_state   <= ST_IDLE;
                            end else begin
                                r_a     <= r_rd;
                                r_rem   <= {1'b0, r_render - r_rd.tstamp};
                                r_den   <= r_prev.tstamp - r_rd.tstamp;
                                r_q     <= '0;
                                r_dcnt  <= '0;
                                r_state <= ST_DIV;
                            end
                        end else begin
                            r_prev <= r_rd;
                            if (r_kd == 5'd0) begin
                                r_iss     <= 1'b0;
                                r_pend    <= 1'b0;
                                r_out_v   <= 1'b1;
                                r_out_res <= 1'b0;
                                r_out_x   <= '0;
                                r_out_y   <= '0;
                                r_state   <= ST_IDLE;
                            end
                        end
                    end
                end
                ST_DIV: begin
                    if (w_rem2 >= {1'b0, r_den}) begin
                        r_rem <= w_rem2 - {1'b0, r_den};
                        r_q   <= {r_q[14:0], 1'b1};
                    end else begin
                        r_rem <= w_rem2;
                        r_q   <= {r_q[14:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 4'd1;
                    if (r_dcnt == 4'd15) begin
                        r_state <= ST_MULX;
                    end
                end
                ST_MULX: begin
                    r_prod  <= w_prod[39:16];
                    r_state <= ST_ADDX;
                end
                ST_ADDX: begin
                    r_xo    <= r_a.x + r_prod;
                    r_prod  <= w_prod[39:16];
                    r_state <= ST_ADDY;
                end
                ST_ADDY: begin
                    r_out_v   <= 1'b1;
                    r_out_res <= 1'b1;
                    r_out_x   <= r_xo;
                    r_out_y   <= r_a.y + r_prod;
                    r_state   <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/timestamped_position_interpolator.sv
`timescale 1ns / 1ps
// Channel   Direction  tuser          tdata (lowest bit up)
// s_axis    in         op [1:0]       slot[3:0] x_pos[27:4] y_pos[51:28] now_ms[83:52]
// m_axis    out        valid_res [0]  x_out[23:0] y_out[47:24]
// cfg       in         -              delay_ms[15:0] on i_cfg_we
//
// Store, remove and unused codes pass the queue and are answered straight from the back end's idle state.
// A query in the back end walks the n held samples through the registered read port,
// runs the bit-serial divider for the 16-bit quotient, then interpolates in the MULX,
// ADDX and ADDY states.
// Reset clears ring pointers and the queue; sample memory holds no reset state.
// A two-entry request queue lets input take up to two requests while a result waits on m_axis_tready.
module timestamped_position_interpolator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,  // op
    input  logic [87:0] s_axis_tdata,  // slot, x_pos, y_pos, now_ms, unused pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic        m_axis_tuser,  // valid_res
    output logic [47:0] m_axis_tdata   // x_out, y_out
);

    tspi_pkg::t_cmd w_push_cmd;
    tspi_pkg::t_cmd w_pop_cmd;
    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;
    logic [23:0]    w_x;
    logic [23:0]    w_y;

    tspi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_slot      (s_axis_tdata[3:0]),
        .i_x         (s_axis_tdata[27:4]),
        .i_y         (s_axis_tdata[51:28]),
        .i_now       (s_axis_tdata[83:52]),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    tspi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .i_pop   (w_pop),
        .o_data  (w_pop_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    tspi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_cmd       (w_pop_cmd),
        .o_pop       (w_pop),
        .o_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .o_res_valid (m_axis_tuser),
        .o_x         (w_x),
        .o_y         (w_y)
    );

    assign m_axis_tdata = {w_y, w_x};

endmodule

// File: design/tspi_checker.sv
`timescale 1ns / 1ps
module tspi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic        m_axis_tuser,
    input logic [47:0] m_axis_tdata
);

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered straight after reset");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 48'd0))
        else $error("invalid result carries nonzero position");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind timestamped_position_interpolator tspi_checker u_tspi_checker (.*);
